FILE: design/cgeu_pkg.sv
// Package for the central gravity Euler step block: beat types, control
// codes, command/status structs and Q32.32 saturating helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cgeu_pkg;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DSQ = 3'd5;

  localparam logic [62:0] GRAV_RST    = 63'd4294967296;
  localparam logic [62:0] DT_RST      = 63'd68719477;
  localparam logic [62:0] MIN_DSQ_RST = 63'd4295;

  // datapath operations
  localparam logic [4:0] OP_NOP     = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_DIFF    = 5'd2;
  localparam logic [4:0] OP_SQ_GO   = 5'd3;
  localparam logic [4:0] OP_SQ_ACC  = 5'd4;
  localparam logic [4:0] OP_ROOT_GO = 5'd5;
  localparam logic [4:0] OP_G_GO    = 5'd6;
  localparam logic [4:0] OP_G_WR    = 5'd7;
  localparam logic [4:0] OP_U_GO    = 5'd8;
  localparam logic [4:0] OP_U_WR    = 5'd9;
  localparam logic [4:0] OP_A_GO    = 5'd10;
  localparam logic [4:0] OP_A_WR    = 5'd11;
  localparam logic [4:0] OP_V_GO    = 5'd12;
  localparam logic [4:0] OP_V_WR    = 5'd13;
  localparam logic [4:0] OP_P_GO    = 5'd14;
  localparam logic [4:0] OP_P_WR    = 5'd15;
  localparam logic [4:0] OP_OUT     = 5'd16;

  localparam logic [1:0] AX_LAST = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] load_pos_x;
    logic [63:0] load_pos_y;
    logic [63:0] load_pos_z;
    logic [63:0] load_vel_x;
    logic [63:0] load_vel_y;
    logic [63:0] load_vel_z;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] out_pos_x;
    logic [63:0] out_pos_y;
    logic [63:0] out_pos_z;
    logic [63:0] out_vel_x;
    logic [63:0] out_vel_y;
    logic [63:0] out_vel_z;
    logic [63:0] out_acc_x;
    logic [63:0] out_acc_y;
    logic [63:0] out_acc_z;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } stat_t;

  function automatic logic [63:0] mag_of(input logic [63:0] v);
    mag_of = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (((a ^ r) & (b ^ r)) >> 63 != 64'd0) add_sat = a[63] ? NEG_MAG : POS_MAX;
    else add_sat = r;
  endfunction

  function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (((a ^ b) & (a ^ r)) >> 63 != 64'd0) sub_sat = a[63] ? NEG_MAG : POS_MAX;
    else sub_sat = r;
  endfunction

endpackage
`default_nettype wire

FILE: design/cgeu_div.sv
// Restoring divider, one quotient bit per cycle: 128-bit dividend over a
// 64-bit divisor, quotient saturated and signed. Uses cgeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cgeu_div (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] num,
  input  wire logic [63:0]  den,
  input  wire logic         neg,
  output logic              busy,
  output logic [63:0]       quo
);
  import cgeu_pkg::*;

  logic [127:0] nsh;
  logic [127:0] q;
  logic [63:0]  rem;
  logic [63:0]  dreg;
  logic [6:0]   cnt;
  logic         nreg;
  logic [64:0]  rs;
  logic         ge;
  logic [63:0]  cap;
  logic [63:0]  m;

  assign rs = {rem, nsh[127]};
  assign ge = rs >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'd127) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      nreg <= neg;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      nsh <= {nsh[126:0], 1'b0};
      rem <= ge ? 64'(rs - {1'b0, dreg}) : rs[63:0];
      q   <= {q[126:0], ge};
    end
  end

  always_comb begin
    cap = nreg ? NEG_MAG : POS_MAX;
    m   = (q[127:64] != 64'd0 || q[63:0] > cap) ? cap : q[63:0];
    quo = nreg ? (64'd0 - m) : m;
  end

endmodule
`default_nettype wire

FILE: design/cgeu_sqrt.sv
// Digit-by-digit integer square root of a 96-bit radicand, two radicand
// bits per cycle. Uses cgeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cgeu_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [95:0] rad,
  output logic             busy,
  output logic [47:0]      root
);
  import cgeu_pkg::*;

  logic [95:0] xsh;
  logic [51:0] rem;
  logic [5:0]  cnt;
  logic [51:0] rs;
  logic [51:0] trial;
  logic        ge;

  assign rs    = {rem[49:0], xsh[95:94]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd47) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xsh  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xsh  <= {xsh[93:0], 2'b00};
      rem  <= ge ? (rs - trial) : rs;
      root <= {root[46:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: design/cgeu_dpath.sv
// Datapath: body state, config registers, iterative 64x64 multiplier,
// divider and root units, output register. Uses cgeu_pkg, cgeu_div, cgeu_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module cgeu_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cgeu_pkg::cmd_t             cmd,
  output cgeu_pkg::stat_t                 stat,
  input  wire cgeu_pkg::in_beat_t         in_data,
  input  wire logic                       cfg_we,
  input  wire logic [cgeu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                cfg_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output cgeu_pkg::out_beat_t             out_data
);
  import cgeu_pkg::*;

  logic [62:0] grav, dt, min_dsq;
  logic [63:0] sun [3];
  logic [63:0] pos [3];
  logic [63:0] vel [3];
  logic [63:0] acc [3];
  logic [63:0] d   [3];
  logic [62:0] rr;
  logic [62:0] g;
  logic [63:0] u;

  // multiplier
  logic [63:0]  ma, mb;
  logic         mneg, mbusy;
  logic [1:0]   mcnt;
  logic [127:0] macc;
  logic [63:0]  mp;
  logic [6:0]   msh;
  logic [63:0]  mcap, mm, mq;

  // shared units
  logic         div_go, sqrt_go;
  logic [127:0] div_num;
  logic [63:0]  div_den;
  logic         div_neg, div_busy, sqrt_busy;
  logic [63:0]  quo;
  logic [47:0]  root;

  logic [62:0] fl, rrf;
  logic [63:0] sq_sum;
  logic [1:0]  ax;

  assign ax = cmd.axis;

  always_comb begin
    mp   = 64'(ma[mcnt[1]*32 +: 32]) * 64'(mb[mcnt[0]*32 +: 32]);
    msh  = {mcnt[1] & mcnt[0], mcnt[1] ^ mcnt[0], 5'd0};
    mcap = mneg ? NEG_MAG : POS_MAX;
    mm   = (macc[127:96] != 32'd0 || macc[95:32] > mcap) ? mcap : macc[95:32];
    mq   = mneg ? (64'd0 - mm) : mm;
  end

  always_comb begin
    fl     = (min_dsq == 63'd0) ? 63'd1 : min_dsq;
    rrf    = (rr < fl) ? fl : rr;
    sq_sum = {1'b0, rr} + {1'b0, mq[62:0]};
  end

  always_comb begin
    div_go  = (cmd.op == OP_G_GO) || (cmd.op == OP_U_GO);
    sqrt_go = (cmd.op == OP_ROOT_GO);
    if (cmd.op == OP_G_GO) begin
      div_num = {33'd0, grav, 32'd0};
      div_den = {1'b0, rr};
      div_neg = 1'b0;
    end else begin
      div_num = {32'd0, mag_of(d[ax]), 32'd0};
      div_den = {16'd0, root};
      div_neg = d[ax][63];
    end
  end

  cgeu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .busy  (div_busy),
    .quo   (quo)
  );

  cgeu_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_go),
    .rad   ({1'b0, rrf, 32'd0}),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      grav    <= GRAV_RST;
      dt      <= DT_RST;
      min_dsq <= MIN_DSQ_RST;
      sun[0]  <= '0;
      sun[1]  <= '0;
      sun[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAV:    grav    <= cfg_data[62:0];
        CFG_DT:      dt      <= cfg_data[62:0];
        CFG_SUN_X:   sun[0]  <= cfg_data;
        CFG_SUN_Y:   sun[1]  <= cfg_data;
        CFG_SUN_Z:   sun[2]  <= cfg_data;
        CFG_MIN_DSQ: min_dsq <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // multiplier control
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (cmd.op == OP_SQ_GO || cmd.op == OP_A_GO ||
                 cmd.op == OP_V_GO || cmd.op == OP_P_GO) begin
      mbusy <= 1'b1;
      mcnt  <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + 2'd1;
      if (mcnt == 2'd3) mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQ_GO: begin
        ma <= mag_of(d[ax]); mb <= mag_of(d[ax]); mneg <= 1'b0; macc <= '0;
      end
      OP_A_GO: begin
        ma <= mag_of(u); mb <= {1'b0, g}; mneg <= u[63]; macc <= '0;
      end
      OP_V_GO: begin
        ma <= mag_of(acc[ax]); mb <= {1'b0, dt}; mneg <= acc[ax][63]; macc <= '0;
      end
      OP_P_GO: begin
        ma <= mag_of(vel[ax]); mb <= {1'b0, dt}; mneg <= vel[ax][63]; macc <= '0;
      end
      default: begin
        if (mbusy) macc <= macc + ({64'd0, mp} << msh);
      end
    endcase
  end

  // body state and step scratch
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        acc[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          pos[0] <= in_data.load_pos_x;
          pos[1] <= in_data.load_pos_y;
          pos[2] <= in_data.load_pos_z;
          vel[0] <= in_data.load_vel_x;
          vel[1] <= in_data.load_vel_y;
          vel[2] <= in_data.load_vel_z;
          for (int i = 0; i < 3; i++) acc[i] <= '0;
        end
        OP_A_WR: acc[ax] <= mq;
        OP_V_WR: vel[ax] <= add_sat(vel[ax], mq);
        OP_P_WR: pos[ax] <= add_sat(pos[ax], mq);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) d[i] <= sub_sat(sun[i], pos[i]);
      end
      OP_SQ_ACC: begin
        if (ax == 2'd0) rr <= mq[62:0];
        else rr <= sq_sum[63] ? POS_MAX[62:0] : sq_sum[62:0];
      end
      OP_ROOT_GO: rr <= rrf;
      OP_G_WR:    g  <= quo[62:0];
      OP_U_WR:    u  <= quo;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data <= '{out_pos_x: pos[0], out_pos_y: pos[1], out_pos_z: pos[2],
                    out_vel_x: vel[0], out_vel_y: vel[1], out_vel_z: vel[2],
                    out_acc_x: acc[0], out_acc_y: acc[1], out_acc_z: acc[2]};
    end
  end

  always_comb begin
    stat.mul_busy  = mbusy;
    stat.div_busy  = div_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

FILE: design/cgeu_ctrl.sv
// Sequencer for one step or load: issues datapath operations per axis and
// waits on unit status. Uses cgeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cgeu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            mode,
  output logic                 in_stall,
  input  wire cgeu_pkg::stat_t stat,
  output cgeu_pkg::cmd_t       cmd
);
  import cgeu_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_SQ_W   = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_ROOT_W = 4'd4;
  localparam logic [3:0] S_G      = 4'd5;
  localparam logic [3:0] S_G_W    = 4'd6;
  localparam logic [3:0] S_U      = 4'd7;
  localparam logic [3:0] S_U_W    = 4'd8;
  localparam logic [3:0] S_A      = 4'd9;
  localparam logic [3:0] S_A_W    = 4'd10;
  localparam logic [3:0] S_V      = 4'd11;
  localparam logic [3:0] S_V_W    = 4'd12;
  localparam logic [3:0] S_P      = 4'd13;
  localparam logic [3:0] S_P_W    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state, state_next;
  logic [1:0] ax, ax_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= '0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ax_next    = ax;
    cmd.op     = OP_NOP;
    cmd.axis   = ax;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ax_next = 2'd0;
          if (!mode) begin
            cmd.op     = OP_LOAD;
            state_next = S_FIN;
          end else begin
            cmd.op     = OP_DIFF;
            state_next = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.op     = OP_SQ_GO;
        state_next = S_SQ_W;
      end
      S_SQ_W: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_SQ_ACC;
          if (ax == AX_LAST) begin
            ax_next    = 2'd0;
            state_next = S_ROOT;
          end else begin
            ax_next    = ax + 2'd1;
            state_next = S_SQ;
          end
        end
      end
      S_ROOT: begin
        cmd.op     = OP_ROOT_GO;
        state_next = S_ROOT_W;
      end
      S_ROOT_W: if (!stat.sqrt_busy) state_next = S_G;
      S_G: begin
        cmd.op     = OP_G_GO;
        state_next = S_G_W;
      end
      S_G_W: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_G_WR;
          state_next = S_U;
        end
      end
      S_U: begin
        cmd.op     = OP_U_GO;
        state_next = S_U_W;
      end
      S_U_W: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_U_WR;
          state_next = S_A;
        end
      end
      S_A: begin
        cmd.op     = OP_A_GO;
        state_next = S_A_W;
      end
      S_A_W: begin
        if (!stat.mul_busy) begin
          cmd.op     = OP_A_WR;
          state_next = S_V;
        end
      end
      S_V: begin
        cmd.op     = OP_V_GO;
        state_next = S_V_W;
      end
      S_V_W: begin
        if (!stat.mul_busy) begin
          cmd.op     = OP_V_WR;
          state_next = S_P;
        end
      end
      S_P: begin
        cmd.op     = OP_P_GO;
        state_next = S_P_W;
      end
      S_P_W: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_P_WR;
          if (ax == AX_LAST) begin
            state_next = S_FIN;
          end else begin
            ax_next    = ax + 2'd1;
            state_next = S_U;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_G_GO || cmd.op == OP_U_GO) |-> !stat.div_busy)
    else $error("divider started while busy");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQ_GO || cmd.op == OP_A_GO || cmd.op == OP_V_GO ||
     cmd.op == OP_P_GO) |-> !stat.mul_busy)
    else $error("multiplier started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> stat.out_free)
    else $error("output register overwritten");

  a_load_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !mode) |=> (state == S_FIN))
    else $error("load beat did not go to finish");

endmodule
`default_nettype wire

FILE: design/central_gravity_euler_step.sv
// Top level of the central gravity Euler step block: sequencer plus datapath.
// Depends on cgeu_pkg, cgeu_ctrl and cgeu_dpath.
`timescale 1ns / 1ps
`default_nettype none
// One body orbiting a fixed attractor, semi-implicit Euler in signed Q32.32.
// A mode-0 beat loads position and velocity and echoes them with zero
// acceleration. A mode-1 beat does one step: offset, squared distance
// (floored at min_dist_sq), root, g = mu/R^2, then per axis direction,
// acceleration, velocity and position. It runs the 1-bit-per-cycle divider
// four times (once for g, once per axis for the direction), the root once
// and the 32x32 multiplier twelve times. One item is worked on at a time;
// in_stall is high from accept until the result is in the output register.
// The output register lets the next beat be accepted while a result still
// waits on out_stall. Config writes are always taken (cfg_ready is tied
// high) and must only come while the block is idle; indexes 6 and 7 are
// ignored.
module central_gravity_euler_step (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire cgeu_pkg::in_beat_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output cgeu_pkg::out_beat_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cgeu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                     cfg_data
);
  import cgeu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes are registered directly, no back-pressure
  assign cfg_ready = 1'b1;

  cgeu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (in_data.mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cgeu_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
